// File: hw/rtl/gcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsp_pkg
// Shared types and constants of the glyph cache shelf packer.
// ----------------------------------------------------------------------------
package gcsp_pkg;

   localparam int SLOTS      = 256;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int COUNT_BITS = SLOT_BITS + 1;
   localparam int MAX_DIM    = 4096;
   localparam int GROW_LIMIT = MAX_DIM / 2;
   localparam int DIM_BITS   = 13;
   localparam int PAD_BITS   = 8;
   localparam int GLYPH_BITS = 8;
   localparam int CODE_BITS  = 16;
   localparam int SUM_BITS   = DIM_BITS + 2;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DIM_BITS-1:0] RESET_ATLAS_WIDTH  = 13'd4096;
   localparam logic [DIM_BITS-1:0] RESET_START_HEIGHT = 13'd16;
   localparam logic [PAD_BITS-1:0] RESET_PAD_X        = 8'd4;
   localparam logic [PAD_BITS-1:0] RESET_PAD_Y        = 8'd4;
   localparam logic [DIM_BITS-1:0] PEN_MAX            = '1;

   typedef enum logic [1:0] {
      REG_ATLAS_WIDTH  = 2'd0,
      REG_START_HEIGHT = 2'd1,
      REG_PAD_X        = 2'd2,
      REG_PAD_Y        = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_NO_FIT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_WRAP,
      ST_NEWROW,
      ST_GROW,
      ST_FITX,
      ST_FITY,
      ST_COMMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] atlas_width;
      logic [DIM_BITS-1:0] start_height;
      logic [PAD_BITS-1:0] pad_x;
      logic [PAD_BITS-1:0] pad_y;
   } cfg_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] left;
      logic [DIM_BITS-1:0] top;
      logic [DIM_BITS-1:0] right;
      logic [DIM_BITS-1:0] bottom;
   } rect_type;

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
      rect_type             rect;
      logic [DIM_BITS-1:0]  height_now;
      logic                 grew;
      status_type           status;
   } rsp_payload_type;

endpackage

// File: hw/rtl/gcsp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsp channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gcsp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] glyph_code;
   logic [7:0]  glyph_width;
   logic [7:0]  glyph_height;

   modport source(output valid, glyph_code, glyph_width, glyph_height, input ready);
   modport sink(input valid, glyph_code, glyph_width, glyph_height, output ready);
endinterface

interface gcsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [7:0]  slot;
   logic [12:0] rect_left;
   logic [12:0] rect_top;
   logic [12:0] rect_right;
   logic [12:0] rect_bottom;
   logic [12:0] height_now;
   logic        grew;
   logic [1:0]  status;

   modport source(output valid, hit, slot, rect_left, rect_top, rect_right, rect_bottom,
                  height_now, grew, status, input ready);
   modport sink(input valid, hit, slot, rect_left, rect_top, rect_right, rect_bottom,
                height_now, grew, status, output ready);
endinterface

// File: hw/rtl/gcsp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsp_csr
// APB-style configuration registers; flags writes that reload the pen.
// ----------------------------------------------------------------------------
module gcsp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gcsp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [gcsp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [gcsp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output gcsp_pkg::cfg_type                    cfg,
   output logic                                 reload
);

   gcsp_pkg::cfg_type       cfg_ff, cfg_in;
   logic                    reload_ff, reload_in;
   logic                    wr_en;
   gcsp_pkg::reg_index_type index;

   assign wr_en = psel & penable & pwrite;
   assign index = gcsp_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      cfg_in    = cfg_ff;
      reload_in = 1'b0;
      if (wr_en) begin
         case (index)
            gcsp_pkg::REG_ATLAS_WIDTH: begin
               cfg_in.atlas_width = pwdata[gcsp_pkg::DIM_BITS-1:0];
            end
            gcsp_pkg::REG_START_HEIGHT: begin
               cfg_in.start_height = pwdata[gcsp_pkg::DIM_BITS-1:0];
               reload_in = 1'b1;
            end
            gcsp_pkg::REG_PAD_X: begin
               cfg_in.pad_x = pwdata[gcsp_pkg::PAD_BITS-1:0];
               reload_in = 1'b1;
            end
            gcsp_pkg::REG_PAD_Y: begin
               cfg_in.pad_y = pwdata[gcsp_pkg::PAD_BITS-1:0];
               reload_in = 1'b1;
            end
            default: begin
               reload_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         gcsp_pkg::REG_ATLAS_WIDTH:  prdata = 32'(cfg_ff.atlas_width);
         gcsp_pkg::REG_START_HEIGHT: prdata = 32'(cfg_ff.start_height);
         gcsp_pkg::REG_PAD_X:        prdata = 32'(cfg_ff.pad_x);
         gcsp_pkg::REG_PAD_Y:        prdata = 32'(cfg_ff.pad_y);
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.atlas_width  <= gcsp_pkg::RESET_ATLAS_WIDTH;
         cfg_ff.start_height <= gcsp_pkg::RESET_START_HEIGHT;
         cfg_ff.pad_x        <= gcsp_pkg::RESET_PAD_X;
         cfg_ff.pad_y        <= gcsp_pkg::RESET_PAD_Y;
         reload_ff           <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         reload_ff <= reload_in;
      end
   end

   assign cfg    = cfg_ff;
   assign reload = reload_ff;

endmodule

// File: hw/rtl/gcsp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsp_alu
// Shared three-input adder with compare against a limit.
// ----------------------------------------------------------------------------
module gcsp_alu (
   input  logic [gcsp_pkg::DIM_BITS:0]     a,
   input  logic [gcsp_pkg::PAD_BITS-1:0]   b,
   input  logic [gcsp_pkg::PAD_BITS-1:0]   c,
   input  logic [gcsp_pkg::DIM_BITS-1:0]   limit,
   output logic [gcsp_pkg::SUM_BITS-1:0]   sum,
   output logic                            sum_ge,
   output logic                            sum_gt
);

   logic [gcsp_pkg::SUM_BITS-1:0] limit_ext;

   assign sum       = gcsp_pkg::SUM_BITS'(a) + gcsp_pkg::SUM_BITS'(b)
                    + gcsp_pkg::SUM_BITS'(c);
   assign limit_ext = gcsp_pkg::SUM_BITS'(limit);
   assign sum_ge    = sum >= limit_ext;
   assign sum_gt    = sum > limit_ext;

endmodule

// File: hw/rtl/glyph_cache_shelf_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_cache_shelf_packer
// Glyph cache lookup with shelf packing of misses into a texture atlas.
// A hit ends the slot walk at the matching slot. A miss walks every cached glyph and
// steps through WRAP, NEWROW and GROW (these two only for a new row), FITX, FITY,
// COMMIT and DONE, with NO_FIT going straight to DONE; a full table reports FULL.
// The slot walk reads one table entry per cycle from the code and rectangle memories.
// One transaction in flight; the next is taken once the result is registered.
// Reset clears the fill count and pen state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module glyph_cache_shelf_packer (
   input  logic                                clock,
   input  logic                                reset,
   gcsp_req_if.sink                            req,
   gcsp_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gcsp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [gcsp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [gcsp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int SB = gcsp_pkg::SLOT_BITS;
   localparam int CB = gcsp_pkg::COUNT_BITS;
   localparam int DB = gcsp_pkg::DIM_BITS;

   gcsp_pkg::cfg_type         cfg;
   logic                      reload;

   gcsp_pkg::state_type       state_ff, state_in;
   logic [15:0]               code_ff, code_in;
   logic [7:0]                w_ff, w_in;
   logic [7:0]                h_ff, h_in;
   logic [CB-1:0]             idx_ff, idx_in;
   logic                      pend_ff, pend_in;
   logic [SB-1:0]             pend_idx_ff, pend_idx_in;
   logic [CB-1:0]             used_ff, used_in;
   logic [DB-1:0]             pen_x_ff, pen_x_in;
   logic [DB-1:0]             pen_y_ff, pen_y_in;
   logic [7:0]                row_h_ff, row_h_in;
   logic [DB-1:0]             atlas_h_ff, atlas_h_in;
   logic [DB-1:0]             x_ff, x_in;
   logic [DB:0]               y_ff, y_in;
   logic [DB-1:0]             ht_ff, ht_in;
   logic                      grew_ff, grew_in;
   logic                      wrap_ff, wrap_in;
   logic [DB-1:0]             right_ff, right_in;
   logic [DB-1:0]             bottom_ff, bottom_in;
   gcsp_pkg::rsp_payload_type res_ff, res_in;
   gcsp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   logic [15:0]               slot_code_mem [gcsp_pkg::SLOTS];
   gcsp_pkg::rect_type        slot_rect_mem [gcsp_pkg::SLOTS];
   logic [15:0]               code_rd_ff;
   gcsp_pkg::rect_type        rect_rd_ff;
   logic                      mem_we;
   logic [SB-1:0]             rd_addr;
   gcsp_pkg::rect_type        wr_rect;

   logic [DB:0]               alu_a;
   logic [7:0]                alu_b;
   logic [7:0]                alu_c;
   logic [DB-1:0]             alu_limit;
   logic [gcsp_pkg::SUM_BITS-1:0] alu_sum;
   logic                      alu_ge;
   logic                      alu_gt;

   logic                      issue;
   logic                      match;

   gcsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg),
      .reload  (reload)
   );

   gcsp_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .c      (alu_c),
      .limit  (alu_limit),
      .sum    (alu_sum),
      .sum_ge (alu_ge),
      .sum_gt (alu_gt)
   );

   assign csr_pready = 1'b1;
   assign req.ready  = (state_ff == gcsp_pkg::ST_IDLE);
   assign issue      = idx_ff < used_ff;
   assign match      = pend_ff && (code_rd_ff == code_ff);
   assign rd_addr    = idx_ff[SB-1:0];
   assign wr_rect    = '{left: x_ff, top: y_ff[DB-1:0], right: right_ff, bottom: bottom_ff};

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = idx_ff[SB-1:0];
      used_in      = used_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      row_h_in     = row_h_ff;
      atlas_h_in   = atlas_h_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ht_in        = ht_ff;
      grew_in      = grew_ff;
      wrap_in      = wrap_ff;
      right_in     = right_ff;
      bottom_in    = bottom_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      mem_we       = 1'b0;
      alu_a        = '0;
      alu_b        = '0;
      alu_c        = '0;
      alu_limit    = '0;

      if (reload && (used_ff == '0)) begin
         pen_x_in   = DB'(cfg.pad_x);
         pen_y_in   = DB'(cfg.pad_y);
         row_h_in   = '0;
         atlas_h_in = cfg.start_height;
      end

      case (state_ff)
         gcsp_pkg::ST_IDLE: begin
            if (req.valid) begin
               code_in  = req.glyph_code;
               w_in     = req.glyph_width;
               h_in     = req.glyph_height;
               idx_in   = '0;
               state_in = gcsp_pkg::ST_SEARCH;
            end
         end
         gcsp_pkg::ST_SEARCH: begin
            res_in            = '0;
            res_in.height_now = atlas_h_ff;
            res_in.status     = gcsp_pkg::STATUS_OK;
            if (match) begin
               res_in.hit  = 1'b1;
               res_in.slot = pend_idx_ff;
               res_in.rect = rect_rd_ff;
               state_in    = gcsp_pkg::ST_DONE;
            end else if (issue) begin
               idx_in  = idx_ff + CB'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               if (used_ff == CB'(gcsp_pkg::SLOTS)) begin
                  res_in.status = gcsp_pkg::STATUS_FULL;
                  state_in      = gcsp_pkg::ST_DONE;
               end else begin
                  state_in = gcsp_pkg::ST_WRAP;
               end
            end
         end
         gcsp_pkg::ST_WRAP: begin
            alu_a     = (DB+1)'(pen_x_ff);
            alu_b     = cfg.pad_x;
            alu_c     = w_ff;
            alu_limit = cfg.atlas_width;
            ht_in     = atlas_h_ff;
            grew_in   = 1'b0;
            wrap_in   = alu_ge;
            if (alu_ge) begin
               x_in     = DB'(cfg.pad_x);
               state_in = gcsp_pkg::ST_NEWROW;
            end else begin
               x_in     = pen_x_ff;
               y_in     = (DB+1)'(pen_y_ff);
               state_in = gcsp_pkg::ST_FITX;
            end
         end
         gcsp_pkg::ST_NEWROW: begin
            alu_a    = (DB+1)'(pen_y_ff);
            alu_b    = row_h_ff;
            alu_c    = cfg.pad_y;
            y_in     = alu_sum[DB:0];
            state_in = gcsp_pkg::ST_GROW;
         end
         gcsp_pkg::ST_GROW: begin
            alu_a     = y_ff;
            alu_b     = cfg.pad_y;
            alu_c     = h_ff;
            alu_limit = ht_ff;
            if (alu_ge && (ht_ff <= DB'(gcsp_pkg::GROW_LIMIT))) begin
               ht_in   = {ht_ff[DB-2:0], 1'b0};
               grew_in = 1'b1;
            end
            state_in = gcsp_pkg::ST_FITX;
         end
         gcsp_pkg::ST_FITX: begin
            alu_a     = (DB+1)'(x_ff);
            alu_b     = w_ff;
            alu_limit = cfg.atlas_width;
            right_in  = alu_sum[DB-1:0];
            if (alu_gt) begin
               res_in.status = gcsp_pkg::STATUS_NO_FIT;
               state_in      = gcsp_pkg::ST_DONE;
            end else begin
               state_in = gcsp_pkg::ST_FITY;
            end
         end
         gcsp_pkg::ST_FITY: begin
            alu_a     = y_ff;
            alu_b     = h_ff;
            alu_limit = ht_ff;
            bottom_in = alu_sum[DB-1:0];
            if (alu_gt) begin
               res_in.status = gcsp_pkg::STATUS_NO_FIT;
               state_in      = gcsp_pkg::ST_DONE;
            end else begin
               state_in = gcsp_pkg::ST_COMMIT;
            end
         end
         gcsp_pkg::ST_COMMIT: begin
            alu_a      = (DB+1)'(x_ff);
            alu_b      = w_ff;
            alu_c      = cfg.pad_x;
            mem_we     = 1'b1;
            used_in    = used_ff + CB'(1);
            pen_x_in   = (alu_sum > gcsp_pkg::SUM_BITS'(gcsp_pkg::PEN_MAX))
                         ? gcsp_pkg::PEN_MAX : alu_sum[DB-1:0];
            pen_y_in   = y_ff[DB-1:0];
            row_h_in   = (wrap_ff || (row_h_ff < h_ff)) ? h_ff : row_h_ff;
            atlas_h_in = ht_ff;
            res_in.slot       = used_ff[SB-1:0];
            res_in.rect       = wr_rect;
            res_in.height_now = ht_ff;
            res_in.grew       = grew_ff;
            state_in          = gcsp_pkg::ST_DONE;
         end
         gcsp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = gcsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcsp_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         pen_x_ff     <= DB'(gcsp_pkg::RESET_PAD_X);
         pen_y_ff     <= DB'(gcsp_pkg::RESET_PAD_Y);
         row_h_ff     <= '0;
         atlas_h_ff   <= gcsp_pkg::RESET_START_HEIGHT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         row_h_ff     <= row_h_in;
         atlas_h_ff   <= atlas_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ht_ff       <= ht_in;
      grew_ff     <= grew_in;
      wrap_ff     <= wrap_in;
      right_ff    <= right_in;
      bottom_ff   <= bottom_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_code_mem[used_ff[SB-1:0]] <= code_ff;
         slot_rect_mem[used_ff[SB-1:0]] <= wr_rect;
      end
      code_rd_ff <= slot_code_mem[rd_addr];
      rect_rd_ff <= slot_rect_mem[rd_addr];
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = rsp_data_ff.hit;
   assign rsp.slot        = rsp_data_ff.slot;
   assign rsp.rect_left   = rsp_data_ff.rect.left;
   assign rsp.rect_top    = rsp_data_ff.rect.top;
   assign rsp.rect_right  = rsp_data_ff.rect.right;
   assign rsp.rect_bottom = rsp_data_ff.rect.bottom;
   assign rsp.height_now  = rsp_data_ff.height_now;
   assign rsp.grew        = rsp_data_ff.grew;
   assign rsp.status      = rsp_data_ff.status;

endmodule

// File: hw/rtl/gcsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsp_checker
// Port-level checks of the glyph cache shelf packer.
// ----------------------------------------------------------------------------
module gcsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [12:0] rsp_rect_left,
   input logic [12:0] rsp_rect_top,
   input logic [12:0] rsp_rect_right,
   input logic [12:0] rsp_rect_bottom,
   input logic        rsp_grew,
   input logic [1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready high right after a transaction");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != gcsp_pkg::STATUS_OK) |->
         !rsp_hit && !rsp_grew && (rsp_rect_left == '0) && (rsp_rect_right == '0))
      else $error("failed transaction carries placement fields");

   a_hit_no_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_status == gcsp_pkg::STATUS_OK) && !rsp_grew)
      else $error("hit reports growth or error");

   a_rect_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == gcsp_pkg::STATUS_OK) |->
         (rsp_rect_right >= rsp_rect_left) && (rsp_rect_bottom >= rsp_rect_top))
      else $error("rectangle edges out of order");

endmodule

bind glyph_cache_shelf_packer gcsp_checker u_gcsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_hit         (rsp.hit),
   .rsp_rect_left   (rsp.rect_left),
   .rsp_rect_top    (rsp.rect_top),
   .rsp_rect_right  (rsp.rect_right),
   .rsp_rect_bottom (rsp.rect_bottom),
   .rsp_grew        (rsp.grew),
   .rsp_status      (rsp.status)
);
